FILE: rtl/core/wbps_pkg.sv
// Shared types and constants for the wildcard byte pattern search block.
package wbps_pkg;

  localparam int unsigned DataW     = 8;
  localparam int unsigned PatRegW   = 64;
  localparam int unsigned MaskW     = 16;
  localparam int unsigned LenW      = 5;
  localparam int unsigned OffsetW   = 12;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned CfgIdxW   = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PATTERN_LOW  = 2'd0,
    CFG_PATTERN_HIGH = 2'd1,
    CFG_WILDCARD     = 2'd2,
    CFG_PATTERN_LEN  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [DataW-1:0] data_byte;
    logic             last_byte;
  } in_word_t;

  typedef struct packed {
    logic               found;
    logic [OffsetW-1:0] match_offset;
  } out_word_t;

  typedef struct packed {
    logic [PatRegW-1:0] pattern_low;
    logic [PatRegW-1:0] pattern_high;
    logic [MaskW-1:0]   wildcard_mask;
    logic [LenW-1:0]    pattern_length;
  } cfg_t;

endpackage

FILE: rtl/core/wbps_cfg_regs.sv
// Configuration register file for the pattern search block.
module wbps_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  wbps_pkg::cfg_idx_e             cfg_idx_i,
  input  logic [wbps_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output wbps_pkg::cfg_t                 cfg_o
);

  wbps_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        wbps_pkg::CFG_PATTERN_LOW:  cfg_d.pattern_low    = cfg_wdata_i;
        wbps_pkg::CFG_PATTERN_HIGH: cfg_d.pattern_high   = cfg_wdata_i;
        wbps_pkg::CFG_WILDCARD:     cfg_d.wildcard_mask  = cfg_wdata_i[wbps_pkg::MaskW-1:0];
        wbps_pkg::CFG_PATTERN_LEN:  cfg_d.pattern_length = cfg_wdata_i[wbps_pkg::LenW-1:0];
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern_low    <= '0;
      cfg_q.pattern_high   <= '0;
      cfg_q.wildcard_mask  <= '0;
      cfg_q.pattern_length <= wbps_pkg::LenW'(1);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/wbps_match.sv
// Byte window, buffer position tracking and parallel wildcard compare.
module wbps_match #(
  parameter int unsigned MAX_PATTERN_BYTES = 16,
  parameter int unsigned MAX_BUFFER_BYTES  = 4096
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  wbps_pkg::in_word_t  word_i,
  input  wbps_pkg::cfg_t      cfg_i,
  output logic                res_valid_o,
  output wbps_pkg::out_word_t res_o
);

  localparam int unsigned WinD  = MAX_PATTERN_BYTES;
  localparam int unsigned IdxW  = (WinD > 1) ? $clog2(WinD) : 1;
  localparam int unsigned CntW  = $clog2(MAX_BUFFER_BYTES + 1);
  localparam int unsigned DiffW = (CntW > wbps_pkg::OffsetW) ? CntW : wbps_pkg::OffsetW;

  logic [wbps_pkg::DataW-1:0] win_q [WinD];
  logic [wbps_pkg::DataW-1:0] win_d [WinD];
  logic [wbps_pkg::DataW-1:0] win_sh [WinD];
  logic [CntW-1:0]            cnt_q, cnt_d, cnt_inc;
  logic                       seen_q, seen_d;

  logic [wbps_pkg::LenW-1:0]  len;
  logic [2*wbps_pkg::PatRegW-1:0] pat;
  logic                       room;
  logic                       win_hit;
  logic                       hit;
  logic [DiffW-1:0]           diff;
  logic [wbps_pkg::LenW-1:0]  tap;

  // Clamp the configured length to the window depth.
  always_comb begin
    if (cfg_i.pattern_length > wbps_pkg::LenW'(MAX_PATTERN_BYTES)) begin
      len = wbps_pkg::LenW'(MAX_PATTERN_BYTES);
    end else begin
      len = cfg_i.pattern_length;
    end
  end

  assign pat     = {cfg_i.pattern_high, cfg_i.pattern_low};
  assign room    = !seen_q && (cnt_q < CntW'(MAX_BUFFER_BYTES));
  assign cnt_inc = cnt_q + CntW'(1);

  // Window as it stands after taking this byte; entry 0 is the newest.
  always_comb begin
    win_sh[0] = word_i.data_byte;
    for (int i = 1; i < WinD; i++) begin
      win_sh[i] = win_q[i-1];
    end
  end

  // Pattern byte j lines up with window entry len-1-j.
  always_comb begin
    win_hit = 1'b1;
    tap     = '0;
    for (int j = 0; j < WinD; j++) begin
      tap = len - wbps_pkg::LenW'(1) - wbps_pkg::LenW'(j);
      if ((wbps_pkg::LenW'(j) < len) && !cfg_i.wildcard_mask[j]) begin
        if (pat[8*j +: 8] != win_sh[tap[IdxW-1:0]]) begin
          win_hit = 1'b0;
        end
      end
    end
  end

  assign hit  = room && (cnt_inc >= CntW'(len)) && win_hit;
  assign diff = DiffW'(cnt_inc) - DiffW'(len);

  always_comb begin
    res_valid_o        = hit || (word_i.last_byte && !seen_q);
    res_o.found        = hit;
    res_o.match_offset = hit ? diff[wbps_pkg::OffsetW-1:0] : '0;
  end

  always_comb begin
    win_d  = win_q;
    cnt_d  = cnt_q;
    seen_d = seen_q;
    if (word_i.last_byte) begin
      // Close the buffer and start clean for the next one.
      for (int i = 0; i < WinD; i++) begin
        win_d[i] = '0;
      end
      cnt_d  = '0;
      seen_d = 1'b0;
    end else if (room) begin
      win_d  = win_sh;
      cnt_d  = cnt_inc;
      seen_d = hit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WinD; i++) begin
        win_q[i] <= '0;
      end
      cnt_q  <= '0;
      seen_q <= 1'b0;
    end else if (step_i) begin
      win_q  <= win_d;
      cnt_q  <= cnt_d;
      seen_q <= seen_d;
    end
  end

endmodule

FILE: rtl/core/wildcard_byte_pattern_search_top.sv
// Top level of the wildcard byte pattern search block.
//
//   channel  | handshake               | word
//   ---------+-------------------------+----------------------------------
//   input    | in_valid_i / in_ready_o | in_word_i  {data_byte, last_byte}
//   output   | out_valid_o/out_ready_i | out_word_o {found, match_offset}
//   config   | cfg_we_i (no wait)      | cfg_idx_i, cfg_wdata_i
//
// One byte is taken per cycle while the output is not stalled. A byte lands in
// the input register, is compared against the pattern while it is held there and
// its result (if any) is loaded into the output register when the stage advances.
// Reset clears the pattern and wildcard registers (the length resets to one), the
// window, the byte count, the match flag and both valid flags.
// A stalled output holds its word; the input register keeps filling as long as
// the compare stage can drain into the output register.
module wildcard_byte_pattern_search_top #(
  parameter int unsigned MAX_PATTERN_BYTES = 16,
  parameter int unsigned MAX_BUFFER_BYTES  = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  wbps_pkg::in_word_t            in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output wbps_pkg::out_word_t           out_word_o,
  input  logic                          cfg_we_i,
  input  wbps_pkg::cfg_idx_e            cfg_idx_i,
  input  logic [wbps_pkg::CfgDataW-1:0] cfg_wdata_i
);

  wbps_pkg::cfg_t      cfg;
  wbps_pkg::in_word_t  in_q;
  logic                in_valid_q;
  wbps_pkg::out_word_t out_q;
  logic                out_valid_q;
  logic                adv;
  logic                res_valid;
  wbps_pkg::out_word_t res;

  wbps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // Advance the compare stage whenever a byte is held and the output register is free or emptying.
  assign adv        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || adv;

  wbps_match #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
    .MAX_BUFFER_BYTES  (MAX_BUFFER_BYTES)
  ) u_match (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (adv),
    .word_i      (in_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Input register: take a new byte when empty or when the held one moves on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_word_i;
    end
  end

  // Output register: load on advance, drop once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= res_valid;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule
